// ===== hdl/tsq_pkg.sv =====
package tsq_pkg;

    // field widths fixed by the interface
    localparam int CMD_W      = 2;
    localparam int DIR_W      = 2;
    localparam int EV_W       = 3;
    localparam int PEND_W     = 12;
    localparam int THR_W      = 10;
    localparam int MS_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_DIRS   = 4;

    localparam int COUNT_MAX_DEF = 1000;
    localparam int TIME_BITS_DEF = 32;

    localparam logic [PEND_W-1:0] PEND_MAX = '1;

    localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(1);
    localparam logic [MS_W-1:0]  DEBOUNCE_RST  = MS_W'(90);
    localparam logic [MS_W-1:0]  STALE_RST     = MS_W'(250);

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_STALE     = CFG_IDX_W'(2);

    localparam logic [DIR_W-1:0] DIR_UP    = DIR_W'(0);
    localparam logic [DIR_W-1:0] DIR_DOWN  = DIR_W'(1);
    localparam logic [DIR_W-1:0] DIR_LEFT  = DIR_W'(2);
    localparam logic [DIR_W-1:0] DIR_RIGHT = DIR_W'(3);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_PULSE = 2'd1,
        CMD_POLL  = 2'd2
    } t_cmd;

    typedef enum logic [EV_W-1:0] {
        EV_NONE     = 3'd0,
        EV_PREV     = 3'd1,
        EV_NEXT     = 3'd2,
        EV_WAKE     = 3'd3,
        EV_STALE    = 3'd4,
        EV_DEBOUNCE = 3'd5
    } t_event;

    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic [MS_W-1:0]  debounce;
        logic [MS_W-1:0]  stale;
    } t_cfg;

endpackage

// ===== hdl/tsq_cfg.sv =====
module tsq_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tsq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tsq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output tsq_pkg::t_cfg                  o_cfg
);
    import tsq_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= THRESHOLD_RST;
            r_cfg.debounce  <= DEBOUNCE_RST;
            r_cfg.stale     <= STALE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_cfg.threshold <= i_cfg_data[THR_W-1:0];
                CFG_DEBOUNCE:  r_cfg.debounce  <= i_cfg_data[MS_W-1:0];
                CFG_STALE:     r_cfg.stale     <= i_cfg_data[MS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/tsq_core.sv =====
module tsq_core #(
    parameter int COUNT_MAX = tsq_pkg::COUNT_MAX_DEF,
    parameter int TIME_BITS = tsq_pkg::TIME_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [tsq_pkg::CMD_W-1:0]  i_cmd,
    input  logic [tsq_pkg::DIR_W-1:0]  i_direction,
    input  logic                       i_screen_asleep,
    input  tsq_pkg::t_cfg              i_cfg,
    output logic [tsq_pkg::EV_W-1:0]   o_event_res,
    output logic [tsq_pkg::PEND_W-1:0] o_pending_pulses
);
    import tsq_pkg::*;

    localparam int CNT_W  = $clog2(COUNT_MAX + 1);
    localparam int AXIS_W = CNT_W + 1;
    localparam int TOT_W  = CNT_W + 2;
    localparam int CMP_W  = (AXIS_W > THR_W) ? AXIS_W : THR_W;
    localparam int SAT_W  = (TOT_W > PEND_W) ? TOT_W : PEND_W;

    logic [CNT_W-1:0]     r_counts [NUM_DIRS];
    logic [CNT_W-1:0]     n_counts [NUM_DIRS];
    logic                 r_pending, n_pending;
    logic [TIME_BITS-1:0] r_time, n_time;
    logic [TIME_BITS-1:0] r_last_step, n_last_step;
    logic [TIME_BITS-1:0] r_last_change, n_last_change;
    logic [TOT_W-1:0]     r_last_total, n_last_total;

    logic [AXIS_W-1:0]    prev_sum, next_sum;
    logic [TOT_W-1:0]     total, new_sum;
    logic [CMP_W-1:0]     thr;
    logic                 hit, changed;
    logic [TIME_BITS-1:0] since_step, since_change;
    t_event               ev;

    assign prev_sum = AXIS_W'(r_counts[DIR_UP]) + AXIS_W'(r_counts[DIR_LEFT]);
    assign next_sum = AXIS_W'(r_counts[DIR_DOWN]) + AXIS_W'(r_counts[DIR_RIGHT]);
    assign total    = TOT_W'(prev_sum) + TOT_W'(next_sum);
    // a zero threshold behaves as one
    assign thr      = (i_cfg.threshold == '0) ? CMP_W'(1) : CMP_W'(i_cfg.threshold);
    assign hit      = (CMP_W'(prev_sum) >= thr) || (CMP_W'(next_sum) >= thr);
    assign changed  = (total != r_last_total);
    assign since_step   = r_time - r_last_step;
    // a change on this poll restarts the idle time
    assign since_change = changed ? '0 : (r_time - r_last_change);

    always_comb begin
        n_counts      = r_counts;
        n_pending     = r_pending;
        n_time        = r_time;
        n_last_step   = r_last_step;
        n_last_change = r_last_change;
        n_last_total  = r_last_total;
        ev            = EV_NONE;
        unique case (t_cmd'(i_cmd))
            CMD_TICK: begin
                n_time = r_time + TIME_BITS'(1);
            end
            CMD_PULSE: begin
                n_pending = 1'b1;
                if (r_counts[i_direction] < CNT_W'(COUNT_MAX)) begin
                    n_counts[i_direction] = r_counts[i_direction] + CNT_W'(1);
                end
            end
            CMD_POLL: begin
                if (r_pending) begin
                    if (changed) begin
                        n_last_change = r_time;
                        n_last_total  = total;
                    end
                    if (hit) begin
                        if (since_step >= TIME_BITS'(i_cfg.debounce)) begin
                            if (i_screen_asleep) begin
                                ev = EV_WAKE;
                            end else begin
                                ev          = (prev_sum >= next_sum) ? EV_PREV : EV_NEXT;
                                n_last_step = r_time;
                            end
                        end else begin
                            ev = EV_DEBOUNCE;
                        end
                        for (int k = 0; k < NUM_DIRS; k++) begin
                            n_counts[k] = '0;
                        end
                        n_pending    = 1'b0;
                        n_last_total = '0;
                    end else if (since_change > TIME_BITS'(i_cfg.stale)) begin
                        ev = EV_STALE;
                        for (int k = 0; k < NUM_DIRS; k++) begin
                            n_counts[k] = '0;
                        end
                        n_pending    = 1'b0;
                        n_last_total = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign new_sum = TOT_W'(n_counts[0]) + TOT_W'(n_counts[1])
                   + TOT_W'(n_counts[2]) + TOT_W'(n_counts[3]);

    assign o_event_res      = ev;
    assign o_pending_pulses = (SAT_W'(new_sum) > SAT_W'(PEND_MAX)) ? PEND_MAX
                                                                   : PEND_W'(new_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_DIRS; k++) begin
                r_counts[k] <= '0;
            end
            r_pending     <= 1'b0;
            r_time        <= '0;
            r_last_step   <= '0;
            r_last_change <= '0;
            r_last_total  <= '0;
        end else if (i_valid) begin
            r_counts      <= n_counts;
            r_pending     <= n_pending;
            r_time        <= n_time;
            r_last_step   <= n_last_step;
            r_last_change <= n_last_change;
            r_last_total  <= n_last_total;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_counts[0] <= CNT_W'(COUNT_MAX)) && (r_counts[1] <= CNT_W'(COUNT_MAX))
        && (r_counts[2] <= CNT_W'(COUNT_MAX)) && (r_counts[3] <= CNT_W'(COUNT_MAX)))
        else $error("direction count above saturation limit");

    a_tick_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_cmd == CMD_TICK)) |=> (r_time == $past(r_time) + TIME_BITS'(1)))
        else $error("tick did not advance the millisecond counter");

    a_step_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && ((ev == EV_PREV) || (ev == EV_NEXT)))
        |=> (r_last_step == $past(r_time)) && !r_pending)
        else $error("step did not record its time or clear pending");

endmodule

// ===== hdl/trackball_step_qualifier_top.sv =====
// channel  | valid       | stall       | payload
// input    | i_in_valid  | o_in_stall  | i_cmd, i_direction, i_screen_asleep
// result   | o_out_valid | i_out_stall | o_event_res, o_pending_pulses
// config   | i_cfg_we    | (none)      | i_cfg_index, i_cfg_data
//
// one item per cycle unless a result stall holds it; results leave via the result register
// the item is evaluated in one pass between the input register and the result register
// reset is synchronous and active low; counts, times and config return to reset values
// a stalled result holds the evaluate stage, which then raises o_in_stall once the
// input register is full
module trackball_step_qualifier_top #(
    parameter int COUNT_MAX = tsq_pkg::COUNT_MAX_DEF,
    parameter int TIME_BITS = tsq_pkg::TIME_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [tsq_pkg::CMD_W-1:0]      i_cmd,
    input  logic [tsq_pkg::DIR_W-1:0]      i_direction,
    input  logic                           i_screen_asleep,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [tsq_pkg::EV_W-1:0]       o_event_res,
    output logic [tsq_pkg::PEND_W-1:0]     o_pending_pulses,
    input  logic                           i_cfg_we,
    input  logic [tsq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tsq_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tsq_pkg::*;

    logic              r_in_valid;
    logic [CMD_W-1:0]  r_cmd;
    logic [DIR_W-1:0]  r_direction;
    logic              r_asleep;
    logic              r_out_valid;
    logic [EV_W-1:0]   r_event;
    logic [PEND_W-1:0] r_pending;

    logic              advance;
    logic [EV_W-1:0]   core_event;
    logic [PEND_W-1:0] core_pending;
    t_cfg              cfg;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    tsq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tsq_core #(
        .COUNT_MAX (COUNT_MAX),
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (advance),
        .i_cmd            (r_cmd),
        .i_direction      (r_direction),
        .i_screen_asleep  (r_asleep),
        .i_cfg            (cfg),
        .o_event_res      (core_event),
        .o_pending_pulses (core_pending)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_cmd       <= i_cmd;
            r_direction <= i_direction;
            r_asleep    <= i_screen_asleep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_event   <= core_event;
            r_pending <= core_pending;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_event_res      = r_event;
    assign o_pending_pulses = r_pending;

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    a_event_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_event != EV_NONE)) |-> (r_pending == '0))
        else $error("qualified event left pulses pending");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
    import tsq_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int BURST_TRIGGER = 150;
    localparam int BURST_CYCLES = 64;

    typedef struct packed {
        t_event            ev;
        logic [PEND_W-1:0] pend;
    } t_step_outcome;

    class t_step_tracker;
        int unsigned                counts[NUM_DIRS];
        bit                         pulses_held;
        logic [TIME_BITS_DEF-1:0]   now_ms;
        logic [TIME_BITS_DEF-1:0]   last_step_ms;
        logic [TIME_BITS_DEF-1:0]   last_change_ms;
        logic [PEND_W-1:0]          last_total;
        logic [THR_W-1:0]           threshold;
        logic [MS_W-1:0]            debounce;
        logic [MS_W-1:0]            stale;
        t_step_outcome              outcomes[$];
        int                         errors;
        int                         checked;
        int                         peak;
        int                         tally[6];

        function new();
            clear_counts();
            now_ms = '0;
            last_step_ms = '0;
            last_change_ms = '0;
            threshold = THRESHOLD_RST;
            debounce = DEBOUNCE_RST;
            stale = STALE_RST;
            errors = 0;
            checked = 0;
            peak = 0;
            foreach (tally[i]) tally[i] = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_THRESHOLD: threshold = val[THR_W-1:0];
                CFG_DEBOUNCE:  debounce = val;
                CFG_STALE:     stale = val;
                default: ;
            endcase
        endfunction

        function void clear_counts();
            foreach (counts[i]) counts[i] = 0;
            pulses_held = 1'b0;
            last_total = '0;
        endfunction

        function t_event evaluate_poll(logic asleep);
            int need;
            int up_left;
            int down_right;
            logic [TIME_BITS_DEF-1:0] since;
            need = (threshold == '0) ? 1 : int'(threshold);
            up_left = counts[DIR_UP] + counts[DIR_LEFT];
            down_right = counts[DIR_DOWN] + counts[DIR_RIGHT];
            if (!pulses_held)
                return EV_NONE;
            if (PEND_W'(up_left + down_right) != last_total) begin
                last_change_ms = now_ms;
                last_total = PEND_W'(up_left + down_right);
            end
            if (up_left >= need || down_right >= need) begin
                since = now_ms - last_step_ms;
                clear_counts();
                if (since < debounce)
                    return EV_DEBOUNCE;
                // a wake poll leaves the step time alone
                if (asleep)
                    return EV_WAKE;
                last_step_ms = now_ms;
                return (up_left >= down_right) ? EV_PREV : EV_NEXT;
            end
            since = now_ms - last_change_ms;
            if (since > stale) begin
                clear_counts();
                return EV_STALE;
            end
            return EV_NONE;
        endfunction

        function void note_item(logic [CMD_W-1:0] cmd, logic [DIR_W-1:0] dir, logic asleep);
            t_step_outcome o;
            int sum;
            o.ev = EV_NONE;
            case (cmd)
                CMD_TICK:  now_ms = now_ms + 1'b1;
                CMD_PULSE: begin
                    pulses_held = 1'b1;
                    if (counts[dir] < COUNT_MAX_DEF)
                        counts[dir]++;
                end
                CMD_POLL:  o.ev = evaluate_poll(asleep);
                default: ;
            endcase
            sum = 0;
            foreach (counts[i]) sum += counts[i];
            if (sum > int'(PEND_MAX))
                sum = int'(PEND_MAX);
            o.pend = PEND_W'(sum);
            if (sum > peak)
                peak = sum;
            tally[o.ev]++;
            outcomes = {outcomes, o};
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40)
                $display("mismatch: %s", what);
        endtask

        task check_result(logic [EV_W-1:0] ev, logic [PEND_W-1:0] pend);
            t_step_outcome want;
            if (outcomes.size() == 0) begin
                report($sformatf("unexpected result: event %0d pending %0d", ev, pend));
                return;
            end
            want = outcomes.pop_front();
            checked++;
            if (ev !== want.ev)
                report($sformatf("result %0d: event %0d, expected %0d",
                                 checked, ev, want.ev));
            if (pend !== want.pend)
                report($sformatf("result %0d: pending %0d, expected %0d",
                                 checked, pend, want.pend));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [CMD_W-1:0]      i_cmd = CMD_TICK;
    logic [DIR_W-1:0]      i_direction = DIR_UP;
    logic                  i_screen_asleep = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [EV_W-1:0]       o_event_res;
    logic [PEND_W-1:0]     o_pending_pulses;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_THRESHOLD;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    t_step_tracker tracker;
    bit            calm = 1'b0;
    int            items_sent = 0;
    int            in_holds = 0;
    int            cycles = 0;

    trackball_step_qualifier_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_direction      (i_direction),
        .i_screen_asleep  (i_screen_asleep),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_event_res      (o_event_res),
        .o_pending_pulses (o_pending_pulses),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    function automatic logic [DIR_W-1:0] rand_dir();
        return DIR_W'($urandom_range(3));
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [DIR_W-1:0] dir,
                             input logic asleep);
        while (!calm && $urandom_range(99) < 19) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_direction <= dir;
        i_screen_asleep <= asleep;
        do begin
            @(posedge i_clk);
            if (o_in_stall)
                in_holds++;
        end while (o_in_stall);
        tracker.note_item(cmd, dir, asleep);
        items_sent++;
    endtask

    task automatic tick();
        send_item(CMD_TICK, rand_dir(), rand_bit());
    endtask

    task automatic pulse(input logic [DIR_W-1:0] dir);
        send_item(CMD_PULSE, dir, rand_bit());
    endtask

    task automatic poll(input logic asleep);
        send_item(CMD_POLL, rand_dir(), asleep);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.outcomes.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // registers only change with the pipeline empty
    task automatic configure(input int thr, input int deb, input int stale_lim);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_THRESHOLD;
        i_cfg_data <= CFG_DATA_W'(thr);
        @(posedge i_clk);
        tracker.set_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
        i_cfg_index <= CFG_DEBOUNCE;
        i_cfg_data <= CFG_DATA_W'(deb);
        @(posedge i_clk);
        tracker.set_reg(CFG_DEBOUNCE, CFG_DATA_W'(deb));
        i_cfg_index <= CFG_STALE;
        i_cfg_data <= CFG_DATA_W'(stale_lim);
        @(posedge i_clk);
        tracker.set_reg(CFG_STALE, CFG_DATA_W'(stale_lim));
        i_cfg_we <= 1'b0;
    endtask

    task automatic directed_checks();
        // still at reset settings: empty poll, unused command, debounced steps
        poll(1'b0);
        send_item(CMD_UNUSED, rand_dir(), rand_bit());
        pulse(DIR_DOWN);
        poll(1'b0);
        pulse(DIR_LEFT);
        poll(1'b1);
        configure(2, 2, 3);
        tick();
        tick();
        pulse(DIR_UP);
        pulse(DIR_LEFT);
        poll(1'b1);
        pulse(DIR_RIGHT);
        pulse(DIR_DOWN);
        poll(1'b0);
        tick();
        tick();
        // equal axes, prev should win
        pulse(DIR_UP);
        pulse(DIR_UP);
        pulse(DIR_DOWN);
        pulse(DIR_RIGHT);
        poll(1'b0);
        // lone pulse left idle until it goes stale
        pulse(DIR_LEFT);
        poll(1'b0);
        repeat (4) tick();
        poll(1'b0);
    endtask

    // unreachable threshold first, so one count runs into its ceiling
    task automatic saturate_counts();
        logic [DIR_W-1:0] d;
        d = rand_dir();
        configure((1 << THR_W) - 1, 0, (1 << MS_W) - 1);
        repeat (COUNT_MAX_DEF + 3) begin
            if ($urandom_range(99) == 0)
                poll(rand_bit());
            pulse(d);
        end
        poll(1'b0);
        configure(COUNT_MAX_DEF, 0, (1 << MS_W) - 1);
        poll(1'b0);
    endtask

    task automatic pulse_run(input int need, input int cap);
        int n;
        bit toward_prev;
        logic [DIR_W-1:0] d;
        n = $urandom_range(need + 2);
        toward_prev = 1'($urandom_range(1));
        repeat (n) begin
            if ($urandom_range(3) == 0)
                tick();
            if ($urandom_range(3) != 0) begin
                if (toward_prev)
                    d = $urandom_range(1) ? DIR_UP : DIR_LEFT;
                else
                    d = $urandom_range(1) ? DIR_DOWN : DIR_RIGHT;
            end else begin
                d = rand_dir();
            end
            pulse(d);
        end
        repeat ($urandom_range(cap)) tick();
        poll($urandom_range(4) == 0);
        if ($urandom_range(3) == 0)
            poll(rand_bit());
    endtask

    task automatic random_phase(input int thr, input int deb, input int stale_lim,
                                input int cap, input int quota, input bit quiet);
        int target;
        int need;
        configure(thr, deb, stale_lim);
        calm = quiet;
        need = (thr == 0) ? 1 : thr;
        target = items_sent + quota;
        while (items_sent < target) begin
            if ($urandom_range(99) < 80)
                pulse_run(need, cap);
            else
                repeat ($urandom_range(1, 3))
                    send_item(CMD_W'($urandom_range(3)), rand_dir(), rand_bit());
        end
        calm = 1'b0;
    endtask

    // result side: random stalls plus one long hold-off to back the block up
    initial begin : result_side
        int hold_left;
        bit squeezed;
        hold_left = 0;
        squeezed = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                tracker.check_result(o_event_res, o_pending_pulses);
            if (!squeezed && tracker.checked >= BURST_TRIGGER) begin
                squeezed = 1'b1;
                hold_left = BURST_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < 19);
            end
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("trackball_step_qualifier_top test failed");
        $finish;
    end

    initial begin : stimulus
        tracker = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_checks();
        saturate_counts();
        random_phase(3, 5, 20, 30, 60, 1'b0);
        random_phase(0, 0, 0, 3, 40, 1'b0);
        random_phase(6, 30, 12, 40, 80, 1'b1);
        random_phase($urandom_range(8), $urandom_range(40), $urandom_range(40), 45, 40, 1'b0);
        random_phase(2, (1 << MS_W) - 1, (1 << MS_W) - 1, 10, 30, 1'b0);
        drain();
        repeat (4) @(posedge i_clk);
        if (tracker.outcomes.size() != 0)
            tracker.report($sformatf("%0d results never arrived", tracker.outcomes.size()));
        $display("%0d items in %0d cycles, %0d results compared, input held off %0d times",
                 items_sent, cycles, tracker.checked, in_holds);
        $display("prev %0d, next %0d, wake %0d, stale %0d, debounced %0d, peak count %0d",
                 tracker.tally[EV_PREV], tracker.tally[EV_NEXT], tracker.tally[EV_WAKE],
                 tracker.tally[EV_STALE], tracker.tally[EV_DEBOUNCE], tracker.peak);
        if (tracker.errors == 0)
            $display("trackball_step_qualifier_top test passed");
        else
            $display("trackball_step_qualifier_top test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/tsq_pkg.sv
hdl/tsq_cfg.sv
hdl/tsq_core.sv
hdl/trackball_step_qualifier_top.sv
tb/sv/testbench.sv
